// File: design/first_fit_block_allocator_core_defines.svh
// ----------------------------------------------------------------------------
// first_fit_block_allocator_core_defines
// assertion macros used by the allocator rtl
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_CORE_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_CORE_DEFINES_SVH

// clocked assertion, disabled while reset is applied
`define FFBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked assertion that is also checked during reset
`define FFBA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: design/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// types and constants of the first-fit block allocator
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int unsigned MAX_BLOCKS = 8;
  localparam int unsigned MAX_ALLOCS = 16;

  localparam int unsigned SIZE_W      = 16;
  localparam int unsigned TAG_W       = 16;
  localparam int unsigned OUT_BLOCK_W = 3;

  // block index, and block counter that can hold MAX_BLOCKS itself
  localparam int unsigned BLK_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned BCNT_W = $clog2(MAX_BLOCKS + 1);
  // allocation slot index and slot counter
  localparam int unsigned SLOT_W = (MAX_ALLOCS > 1) ? $clog2(MAX_ALLOCS) : 1;
  localparam int unsigned SCNT_W = $clog2(MAX_ALLOCS + 1);

  typedef enum logic [1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_ALLOC = 2'd1,
    FUNC_FREE  = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOFIT = 2'd1,
    ST_NOTAG = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMD,
    S_BRD,
    S_BCHK,
    S_ARD,
    S_ACHK,
    S_FWR,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [BLK_W-1:0]  blk;
    logic [SIZE_W-1:0] size;
  } alloc_entry_t;

endpackage

// File: design/first_fit_block_allocator_core.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator_core
// first-fit allocator over a block table and an allocation table
// ----------------------------------------------------------------------------
// One transaction is taken at a time and gives exactly one result. Block
// sizes and allocation records sit in two synchronous memories with one
// write and one registered read port each, and allocate and free are
// read-modify-write sequences on them. Allocate reads the blocks in order up
// to and including the first fit, or all of them when none fits; free reads
// the allocation slots in order up to and including the match, or all of them
// when the tag is not found. An allocate into a full allocation table ends
// without a block search. A new transaction is accepted in the cycle after
// the result enters the output register, even while that result still waits
// to be taken.

`include "first_fit_block_allocator_core_defines.svh"

module first_fit_block_allocator_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         func_i,
  input  logic [ffba_pkg::SIZE_W-1:0]        req_size_i,
  input  logic [ffba_pkg::TAG_W-1:0]         req_tag_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [1:0]                         status_o,
  output logic [ffba_pkg::TAG_W-1:0]         out_tag_o,
  output logic [ffba_pkg::OUT_BLOCK_W-1:0]   out_block_o,
  output logic [ffba_pkg::SIZE_W-1:0]        block_left_o
);

  localparam int unsigned SIZE_W = ffba_pkg::SIZE_W;
  localparam int unsigned TAG_W  = ffba_pkg::TAG_W;
  localparam int unsigned OBW    = ffba_pkg::OUT_BLOCK_W;
  localparam int unsigned BLK_W  = ffba_pkg::BLK_W;
  localparam int unsigned BCNT_W = ffba_pkg::BCNT_W;
  localparam int unsigned SLOT_W = ffba_pkg::SLOT_W;
  localparam int unsigned SCNT_W = ffba_pkg::SCNT_W;
  localparam int unsigned NBLK   = ffba_pkg::MAX_BLOCKS;
  localparam int unsigned NALLOC = ffba_pkg::MAX_ALLOCS;

  ffba_pkg::state_e state_q, state_d;

  // latched request
  logic [1:0]        func_q;
  logic [SIZE_W-1:0] size_q;
  logic [TAG_W-1:0]  tag_q;

  // allocator state kept in flops
  logic [BCNT_W-1:0] blk_count_q, blk_count_d;
  logic [TAG_W-1:0]  next_tag_q, next_tag_d;
  logic [NALLOC-1:0] valid_q, valid_d;

  // scan counters and free bookkeeping
  logic [BCNT_W-1:0] blk_idx_q, blk_idx_d;
  logic [SCNT_W-1:0] slot_idx_q, slot_idx_d;
  logic [SLOT_W-1:0] new_slot_q, new_slot_d;
  logic [BLK_W-1:0]  f_blk_q, f_blk_d;
  logic [SIZE_W-1:0] f_size_q, f_size_d;

  // pending result
  ffba_pkg::status_e res_status_q, res_status_d;
  logic [TAG_W-1:0]  res_tag_q, res_tag_d;
  logic [OBW-1:0]    res_blk_q, res_blk_d;
  logic [SIZE_W-1:0] res_left_q, res_left_d;

  // output register
  logic              out_valid_q;
  logic [1:0]        out_status_q;
  logic [TAG_W-1:0]  out_tag_q;
  logic [OBW-1:0]    out_blk_q;
  logic [SIZE_W-1:0] out_left_q;

  // block memory
  logic [SIZE_W-1:0] blk_mem [NBLK];
  logic              b_we, b_re;
  logic [BLK_W-1:0]  b_waddr, b_raddr;
  logic [SIZE_W-1:0] b_wdata, b_rdata_q;

  // allocation memory
  ffba_pkg::alloc_entry_t alloc_mem [NALLOC];
  logic                   a_we, a_re;
  logic [SLOT_W-1:0]      a_waddr, a_raddr;
  ffba_pkg::alloc_entry_t a_wdata, a_rdata_q;

  logic              in_fire;
  logic              out_free;
  logic              slot_found;
  logic [SLOT_W-1:0] slot_free;
  logic              fit;
  logic [SIZE_W-1:0] fit_left;
  logic              tag_match;
  logic [SIZE_W:0]   credit_sum;
  logic [SIZE_W-1:0] credit_sat;

  assign in_ready_o = (state_q == ffba_pkg::S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // lowest-numbered free allocation slot
  always_comb begin
    slot_found = 1'b0;
    slot_free  = '0;
    for (int i = NALLOC - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        slot_found = 1'b1;
        slot_free  = SLOT_W'(i);
      end
    end
  end

  assign fit        = (b_rdata_q >= size_q);
  assign fit_left   = b_rdata_q - size_q;
  assign tag_match  = valid_q[slot_idx_q[SLOT_W-1:0]] && (a_rdata_q.tag == tag_q);
  assign credit_sum = {1'b0, b_rdata_q} + {1'b0, f_size_q};
  assign credit_sat = credit_sum[SIZE_W] ? {SIZE_W{1'b1}} : credit_sum[SIZE_W-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ffba_pkg::S_IDLE: begin
        if (in_fire) state_d = ffba_pkg::S_CMD;
      end
      ffba_pkg::S_CMD: begin
        unique case (func_q)
          ffba_pkg::FUNC_ALLOC: state_d = slot_found ? ffba_pkg::S_BRD : ffba_pkg::S_RESP;
          ffba_pkg::FUNC_FREE:  state_d = ffba_pkg::S_ARD;
          default:              state_d = ffba_pkg::S_RESP;
        endcase
      end
      ffba_pkg::S_BRD: begin
        state_d = (blk_idx_q >= blk_count_q) ? ffba_pkg::S_RESP : ffba_pkg::S_BCHK;
      end
      ffba_pkg::S_BCHK: begin
        state_d = fit ? ffba_pkg::S_RESP : ffba_pkg::S_BRD;
      end
      ffba_pkg::S_ARD: begin
        state_d = (slot_idx_q == SCNT_W'(NALLOC)) ? ffba_pkg::S_RESP : ffba_pkg::S_ACHK;
      end
      ffba_pkg::S_ACHK: begin
        state_d = tag_match ? ffba_pkg::S_FWR : ffba_pkg::S_ARD;
      end
      ffba_pkg::S_FWR: begin
        state_d = ffba_pkg::S_RESP;
      end
      ffba_pkg::S_RESP: begin
        if (out_free) state_d = ffba_pkg::S_IDLE;
      end
      default: state_d = ffba_pkg::S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    blk_count_d  = blk_count_q;
    next_tag_d   = next_tag_q;
    valid_d      = valid_q;
    blk_idx_d    = blk_idx_q;
    slot_idx_d   = slot_idx_q;
    new_slot_d   = new_slot_q;
    f_blk_d      = f_blk_q;
    f_size_d     = f_size_q;
    res_status_d = res_status_q;
    res_tag_d    = res_tag_q;
    res_blk_d    = res_blk_q;
    res_left_d   = res_left_q;
    b_we         = 1'b0;
    b_waddr      = blk_idx_q[BLK_W-1:0];
    b_wdata      = size_q;
    b_re         = 1'b0;
    b_raddr      = blk_idx_q[BLK_W-1:0];
    a_we         = 1'b0;
    a_waddr      = new_slot_q;
    a_wdata      = '{tag: next_tag_q, blk: blk_idx_q[BLK_W-1:0], size: size_q};
    a_re         = 1'b0;
    a_raddr      = slot_idx_q[SLOT_W-1:0];

    unique case (state_q)
      ffba_pkg::S_CMD: begin
        res_status_d = ffba_pkg::ST_OK;
        res_tag_d    = '0;
        res_blk_d    = '0;
        res_left_d   = '0;
        blk_idx_d    = '0;
        slot_idx_d   = '0;
        new_slot_d   = slot_free;
        unique case (func_q)
          ffba_pkg::FUNC_ADD: begin
            if (blk_count_q == BCNT_W'(NBLK)) begin
              res_status_d = ffba_pkg::ST_FULL;
            end else begin
              b_we        = 1'b1;
              b_waddr     = blk_count_q[BLK_W-1:0];
              res_blk_d   = OBW'(blk_count_q);
              res_left_d  = size_q;
              blk_count_d = blk_count_q + 1'b1;
            end
          end
          ffba_pkg::FUNC_ALLOC: begin
            if (!slot_found) res_status_d = ffba_pkg::ST_FULL;
          end
          default: ;
        endcase
      end
      ffba_pkg::S_BRD: begin
        if (blk_idx_q >= blk_count_q) begin
          res_status_d = ffba_pkg::ST_NOFIT;
        end else begin
          b_re = 1'b1;
        end
      end
      ffba_pkg::S_BCHK: begin
        if (fit) begin
          b_we                = 1'b1;
          b_wdata             = fit_left;
          a_we                = 1'b1;
          valid_d[new_slot_q] = 1'b1;
          next_tag_d          = next_tag_q + 1'b1;
          res_tag_d           = next_tag_q;
          res_blk_d           = OBW'(blk_idx_q[BLK_W-1:0]);
          res_left_d          = fit_left;
        end else begin
          blk_idx_d = blk_idx_q + 1'b1;
        end
      end
      ffba_pkg::S_ARD: begin
        if (slot_idx_q == SCNT_W'(NALLOC)) begin
          res_status_d = ffba_pkg::ST_NOTAG;
        end else begin
          a_re = 1'b1;
        end
      end
      ffba_pkg::S_ACHK: begin
        if (tag_match) begin
          valid_d[slot_idx_q[SLOT_W-1:0]] = 1'b0;
          b_re     = 1'b1;
          b_raddr  = a_rdata_q.blk;
          f_blk_d  = a_rdata_q.blk;
          f_size_d = a_rdata_q.size;
        end else begin
          slot_idx_d = slot_idx_q + 1'b1;
        end
      end
      ffba_pkg::S_FWR: begin
        b_we       = 1'b1;
        b_waddr    = f_blk_q;
        b_wdata    = credit_sat;
        res_blk_d  = OBW'(f_blk_q);
        res_left_d = credit_sat;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ffba_pkg::S_IDLE;
      blk_count_q <= '0;
      next_tag_q  <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      blk_count_q <= blk_count_d;
      next_tag_q  <= next_tag_d;
      valid_q     <= valid_d;
      if (state_q == ffba_pkg::S_RESP && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      func_q <= func_i;
      size_q <= req_size_i;
      tag_q  <= req_tag_i;
    end
    blk_idx_q    <= blk_idx_d;
    slot_idx_q   <= slot_idx_d;
    new_slot_q   <= new_slot_d;
    f_blk_q      <= f_blk_d;
    f_size_q     <= f_size_d;
    res_status_q <= res_status_d;
    res_tag_q    <= res_tag_d;
    res_blk_q    <= res_blk_d;
    res_left_q   <= res_left_d;
    if (state_q == ffba_pkg::S_RESP && out_free) begin
      out_status_q <= res_status_q;
      out_tag_q    <= res_tag_q;
      out_blk_q    <= res_blk_q;
      out_left_q   <= res_left_q;
    end
  end

  // block memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (b_we) blk_mem[b_waddr] <= b_wdata;
    if (b_re) b_rdata_q <= blk_mem[b_raddr];
  end

  // allocation record memory
  always_ff @(posedge clk_i) begin
    if (a_we) alloc_mem[a_waddr] <= a_wdata;
    if (a_re) a_rdata_q <= alloc_mem[a_raddr];
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign out_tag_o    = out_tag_q;
  assign out_block_o  = out_blk_q;
  assign block_left_o = out_left_q;

  // ------------------------------------------------------------------------
  // assertions
  // ------------------------------------------------------------------------
  `FFBA_ASSERT_ALWAYS(a_blk_count_range, (blk_count_q <= BCNT_W'(NBLK)), "block count overflow")
  `FFBA_ASSERT(a_alloc_sets_one, (state_q == ffba_pkg::S_BCHK && fit) |=> ($countones(valid_q) == $past($countones(valid_q)) + 1), "allocate did not claim exactly one slot")
  `FFBA_ASSERT(a_free_clears_one, (state_q == ffba_pkg::S_ACHK && tag_match) |=> ($countones(valid_q) + 1 == $past($countones(valid_q))), "free did not release exactly one slot")
  `FFBA_ASSERT(a_tag_only_on_alloc, (!$stable(next_tag_q)) |-> $past(state_q == ffba_pkg::S_BCHK && fit), "tag counter moved without an allocation")
  `FFBA_ASSERT(a_accept_dispatch, (in_valid_i && in_ready_o) |=> (state_q == ffba_pkg::S_CMD && !in_ready_o), "accepted transaction not dispatched")

endmodule

// File: dv/first_fit_block_allocator_core_tb.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator_core_tb
// self-checking testbench of the first-fit block allocator
// ----------------------------------------------------------------------------
// Requests go in over a valid/ready channel and every accepted transaction is
// run through a behavioral copy of the block and allocation tables in a small
// scoreboard class, which queues the one result it must produce. Results are
// compared field by field in order. A directed opening covers the block table
// limit and every operation, and random bursts then fill and drain the
// allocation table with mostly fitting requests.
// Both sides insert random gaps and stalls.

module first_fit_block_allocator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SIZE_W      = ffba_pkg::SIZE_W;
  localparam int unsigned TAG_W       = ffba_pkg::TAG_W;
  localparam int unsigned OUT_BLOCK_W = ffba_pkg::OUT_BLOCK_W;
  localparam int unsigned MAX_BLOCKS  = ffba_pkg::MAX_BLOCKS;
  localparam int unsigned MAX_ALLOCS  = ffba_pkg::MAX_ALLOCS;

  localparam logic [1:0]  FUNC_NOP    = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned RAND_HALF   = 560;

  typedef struct {
    ffba_pkg::status_e        status;
    logic [TAG_W-1:0]         tag;
    logic [OUT_BLOCK_W-1:0]   blk;
    logic [SIZE_W-1:0]        left;
  } alloc_result_t;

  class allocator_scoreboard;
    logic [SIZE_W-1:0] blk_left [MAX_BLOCKS];
    int unsigned       n_blocks;
    bit                slot_live [MAX_ALLOCS];
    logic [TAG_W-1:0]  slot_tag [MAX_ALLOCS];
    int                slot_blk [MAX_ALLOCS];
    logic [SIZE_W-1:0] slot_size [MAX_ALLOCS];
    logic [TAG_W-1:0]  tag_next;
    alloc_result_t     pending_results [$];
    int unsigned       n_errors;
    int unsigned       n_checked;
    int unsigned       status_seen [4];

    function new();
      n_blocks  = 0;
      tag_next  = '0;
      n_errors  = 0;
      n_checked = 0;
      foreach (slot_live[i]) slot_live[i] = 1'b0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    // update the tables for one accepted transaction and queue its result
    function void note_request(logic [1:0] op, logic [SIZE_W-1:0] size,
                               logic [TAG_W-1:0] tag);
      alloc_result_t  r;
      int             slot;
      int             hit;
      logic [SIZE_W:0] sum;
      r.status = ffba_pkg::ST_OK;
      r.tag    = '0;
      r.blk    = '0;
      r.left   = '0;
      case (op)
        ffba_pkg::FUNC_ADD: begin
          if (n_blocks >= MAX_BLOCKS) begin
            r.status = ffba_pkg::ST_FULL;
          end else begin
            blk_left[n_blocks] = size;
            r.blk  = OUT_BLOCK_W'(n_blocks);
            r.left = size;
            n_blocks++;
          end
        end
        ffba_pkg::FUNC_ALLOC: begin
          slot = -1;
          hit  = -1;
          for (int i = MAX_ALLOCS - 1; i >= 0; i--)
            if (!slot_live[i]) slot = i;
          for (int i = int'(n_blocks) - 1; i >= 0; i--)
            if (blk_left[i] >= size) hit = i;
          // a full allocation table wins over the block search
          if (slot < 0) begin
            r.status = ffba_pkg::ST_FULL;
          end else if (hit < 0) begin
            r.status = ffba_pkg::ST_NOFIT;
          end else begin
            blk_left[hit]   = blk_left[hit] - size;
            slot_live[slot] = 1'b1;
            slot_tag[slot]  = tag_next;
            slot_blk[slot]  = hit;
            slot_size[slot] = size;
            r.tag  = tag_next;
            r.blk  = OUT_BLOCK_W'(hit);
            r.left = blk_left[hit];
            tag_next++;
          end
        end
        ffba_pkg::FUNC_FREE: begin
          hit = -1;
          // duplicate tags after a wrap: lowest slot goes first
          for (int i = MAX_ALLOCS - 1; i >= 0; i--)
            if (slot_live[i] && slot_tag[i] == tag) hit = i;
          if (hit < 0) begin
            r.status = ffba_pkg::ST_NOTAG;
          end else begin
            slot_live[hit] = 1'b0;
            sum = {1'b0, blk_left[slot_blk[hit]]} + {1'b0, slot_size[hit]};
            blk_left[slot_blk[hit]] = sum[SIZE_W] ? '1 : sum[SIZE_W-1:0];
            r.blk  = OUT_BLOCK_W'(slot_blk[hit]);
            r.left = blk_left[slot_blk[hit]];
          end
        end
        default: ; // unused code leaves the tables alone
      endcase
      pending_results.push_back(r);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want_v);
      n_errors++;
      $display("[%0t] result %0d %s: got 0x%0h, expected 0x%0h",
               $time, n_checked, what, got, want_v);
    endtask

    task check_result(logic [1:0] st, logic [TAG_W-1:0] tag,
                      logic [OUT_BLOCK_W-1:0] blk, logic [SIZE_W-1:0] left);
      alloc_result_t want;
      if (pending_results.size() == 0) begin
        report_mismatch("arrived with nothing pending, status", 32'(st), 32'd0);
        return;
      end
      want = pending_results.pop_front();
      if (st !== want.status) report_mismatch("status", 32'(st), 32'(want.status));
      if (tag !== want.tag) report_mismatch("out_tag", 32'(tag), 32'(want.tag));
      if (blk !== want.blk) report_mismatch("out_block", 32'(blk), 32'(want.blk));
      if (left !== want.left) report_mismatch("block_left", 32'(left), 32'(want.left));
      status_seen[want.status]++;
      n_checked++;
    endtask

    function bit pick_live_tag(output logic [TAG_W-1:0] tag);
      int unsigned live_idx [$];
      foreach (slot_live[i]) if (slot_live[i]) live_idx.push_back(i);
      tag = '0;
      if (live_idx.size() == 0) return 1'b0;
      tag = slot_tag[live_idx[$urandom_range(0, live_idx.size() - 1)]];
      return 1'b1;
    endfunction
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic [1:0]              func_i;
  logic [SIZE_W-1:0]       req_size_i;
  logic [TAG_W-1:0]        req_tag_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic [1:0]              status_o;
  logic [TAG_W-1:0]        out_tag_o;
  logic [OUT_BLOCK_W-1:0]  out_block_o;
  logic [SIZE_W-1:0]       block_left_o;

  allocator_scoreboard sb;
  bit          idle_en;
  int unsigned n_sent;
  int unsigned cycle_cnt;

  first_fit_block_allocator_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .req_size_i  (req_size_i),
    .req_tag_i   (req_tag_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .out_tag_o   (out_tag_o),
    .out_block_o (out_block_o),
    .block_left_o(block_left_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // mostly short idle stretches, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 93) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  task automatic send_req(input logic [1:0] op, input logic [SIZE_W-1:0] size,
                          input logic [TAG_W-1:0] tag);
    int unsigned gap;
    gap = (idle_en && $urandom_range(0, 99) >= 50) ? idle_len() : 0;
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    func_i     <= op;
    req_size_i <= size;
    req_tag_i  <= tag;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(op, size, tag);
    n_sent++;
  endtask

  // request size aimed at the current block capacities
  function automatic logic [SIZE_W-1:0] pick_alloc_size();
    int unsigned k;
    int unsigned rem;
    k = $urandom_range(0, 9);
    if (sb.n_blocks == 0) return SIZE_W'($urandom_range(0, 255));
    rem = sb.blk_left[$urandom_range(0, sb.n_blocks - 1)];
    if (k < 3) return SIZE_W'(rem);
    if (k == 3) return (rem < 65535) ? SIZE_W'(rem + 1) : SIZE_W'(rem);
    if (k < 6) return SIZE_W'($urandom_range(0, 255));
    if (k < 8) return SIZE_W'($urandom_range(0, rem));
    return SIZE_W'($urandom_range(0, 65535));
  endfunction

  task automatic run_random(input int unsigned n_items);
    int unsigned done;
    int unsigned burst;
    int unsigned r;
    bit          fill;
    logic [TAG_W-1:0] t;
    done = 0;
    while (done < n_items) begin
      burst   = $urandom_range(10, 60);
      idle_en = ($urandom_range(0, 3) != 0);
      fill    = 1'($urandom_range(0, 1));
      repeat (burst) begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          send_req(FUNC_NOP, SIZE_W'($urandom_range(0, 65535)),
                   TAG_W'($urandom_range(0, 65535)));
        end else begin
          if (r < 8)
            send_req(ffba_pkg::FUNC_ADD, SIZE_W'($urandom_range(0, 65535)), '0);
          else if (r < (fill ? 70 : 40))
            send_req(ffba_pkg::FUNC_ALLOC, pick_alloc_size(), '0);
          else if ($urandom_range(0, 9) != 0 && sb.pick_live_tag(t))
            send_req(ffba_pkg::FUNC_FREE, '0, t);
          else
            send_req(ffba_pkg::FUNC_FREE, '0, TAG_W'($urandom_range(0, 65535)));
          done++;
        end
      end
    end
  endtask

  // result side: random stalls on out_ready_i
  initial begin : result_sink
    int unsigned stall;
    stall       = 0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else begin
        out_ready_i <= 1'b1;
        if (idle_en && $urandom_range(0, 99) < 25) stall = idle_len();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(status_o, out_tag_o, out_block_o, block_left_o);
  end

  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d results outstanding",
             cycle_cnt, sb.pending_results.size());
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    sb         = new();
    idle_en    = 1'b0;
    n_sent     = 0;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    func_i     = ffba_pkg::FUNC_ADD;
    req_size_i = '0;
    req_tag_i  = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // empty tables, then fill the block table past its limit
    idle_en = 1'b1;
    send_req(ffba_pkg::FUNC_ALLOC, '0, '0);
    send_req(ffba_pkg::FUNC_FREE, '0, '0);
    send_req(FUNC_NOP, 16'hFFFF, 16'hFFFF);
    send_req(ffba_pkg::FUNC_ADD, 16'h0000, '0);
    send_req(ffba_pkg::FUNC_ADD, 16'hFFFF, '0);
    send_req(ffba_pkg::FUNC_ADD, 16'd100, '0);
    send_req(ffba_pkg::FUNC_ADD, 16'd1000, '0);
    send_req(ffba_pkg::FUNC_ADD, 16'h5555, '0);
    send_req(ffba_pkg::FUNC_ADD, 16'hAAAA, '0);
    send_req(ffba_pkg::FUNC_ADD, 16'd1, '0);
    send_req(ffba_pkg::FUNC_ADD, 16'd50, '0);
    send_req(ffba_pkg::FUNC_ADD, 16'd7, '0);
    // zero-size fit, whole-block fit, no fit, exact fit
    send_req(ffba_pkg::FUNC_ALLOC, 16'd0, '0);
    send_req(ffba_pkg::FUNC_ALLOC, 16'hFFFF, '0);
    send_req(ffba_pkg::FUNC_ALLOC, 16'hFFFF, '0);
    send_req(ffba_pkg::FUNC_ALLOC, 16'd60, '0);
    send_req(ffba_pkg::FUNC_ALLOC, 16'd40, '0);
    send_req(ffba_pkg::FUNC_FREE, '0, 16'd1);
    send_req(ffba_pkg::FUNC_FREE, '0, 16'd1);
    send_req(ffba_pkg::FUNC_FREE, '0, 16'hFFFF);
    send_req(ffba_pkg::FUNC_FREE, '0, 16'd0);
    send_req(FUNC_NOP, 16'h1234, 16'h00FF);

    run_random(RAND_HALF);
    run_random(RAND_HALF);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    idle_en = 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("%0d transactions checked in %0d cycles of mixed traffic",
             sb.n_checked, cycle_cnt);
    $display("ok %0d, no fit %0d, tag not found %0d, table full %0d, mismatches %0d",
             sb.status_seen[ffba_pkg::ST_OK], sb.status_seen[ffba_pkg::ST_NOFIT],
             sb.status_seen[ffba_pkg::ST_NOTAG], sb.status_seen[ffba_pkg::ST_FULL],
             sb.n_errors);
    if (sb.n_errors == 0 && sb.n_checked == n_sent)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/ffba_pkg.sv
design/first_fit_block_allocator_core.sv
dv/first_fit_block_allocator_core_tb.sv
